// ===== rtl/core/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared widths, types and arithmetic steps for the tangent/bitangent pipeline.
// ----------------------------------------------------------------------------
package ttb_pkg;

	localparam int COMP_W            = 16;
	localparam int POS_W             = 3 * COMP_W;
	localparam int UV_W              = 2 * COMP_W;
	localparam int DELTA_W           = COMP_W + 1;
	localparam int PROD_W            = 2 * DELTA_W;
	localparam int VEC_W             = PROD_W + 1;
	localparam int MAG_W             = VEC_W - 1;
	localparam int NORM_W            = 30;
	localparam int SQR_W             = 2 * NORM_W;
	localparam int SUM_W             = SQR_W + 2;
	localparam int ROOT_W            = SUM_W / 2;
	localparam int DEN_W             = ROOT_W + 1;
	localparam int REM_W             = ROOT_W + 3;
	localparam int LEAD_W            = 6;
	localparam int SQ_STEPS          = ROOT_W;
	localparam int STEPS_PER_STG     = 2;
	localparam int SQ_STG            = (SQ_STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;
	localparam int OUT_FRAC_BITS_DEF = 14;
	localparam int Q_SAT             = 2 ** (COMP_W - 1) - 1;

	typedef logic signed [VEC_W-1:0] vec3_t [3];

	typedef struct packed {
		logic       degen;
		logic [2:0] tneg;
		logic [2:0] bneg;
	} meta_t;

	typedef struct packed {
		logic [SUM_W-1:0]  bits;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_st_t;

	// One digit of a restoring square root: take two radicand bits, try root*4+1.
	function automatic sqrt_st_t sqrt_step(sqrt_st_t st);
		sqrt_st_t         nx;
		logic [REM_W-1:0] trial;
		nx.bits = {st.bits[SUM_W-3:0], 2'b00};
		nx.rem  = {st.rem[REM_W-3:0], st.bits[SUM_W-1:SUM_W-2]};
		trial   = {1'b0, st.root, 2'b01};
		if (nx.rem >= trial) begin
			nx.rem  = nx.rem - trial;
			nx.root = {st.root[ROOT_W-2:0], 1'b1};
		end else begin
			nx.root = {st.root[ROOT_W-2:0], 1'b0};
		end
		return nx;
	endfunction

	function automatic int div_stages(int frac);
		return (frac + 1 + STEPS_PER_STG - 1) / STEPS_PER_STG;
	endfunction

	function automatic int unit_latency(int frac);
		return 5 + SQ_STG + div_stages(frac);
	endfunction

endpackage

// ===== rtl/core/ttb_in_if.sv =====
// ----------------------------------------------------------------------------
// ttb_in_if
// Triangle input channel: three positions and three texture coordinates.
// ----------------------------------------------------------------------------
interface ttb_in_if;
	logic                       valid;
	logic                       ready;
	logic [ttb_pkg::POS_W-1:0]  vertex0_position;
	logic [ttb_pkg::POS_W-1:0]  vertex1_position;
	logic [ttb_pkg::POS_W-1:0]  vertex2_position;
	logic [ttb_pkg::UV_W-1:0]   vertex0_texcoord;
	logic [ttb_pkg::UV_W-1:0]   vertex1_texcoord;
	logic [ttb_pkg::UV_W-1:0]   vertex2_texcoord;

	modport source (
		output valid, vertex0_position, vertex1_position, vertex2_position,
		output vertex0_texcoord, vertex1_texcoord, vertex2_texcoord,
		input  ready
	);
	modport sink (
		input  valid, vertex0_position, vertex1_position, vertex2_position,
		input  vertex0_texcoord, vertex1_texcoord, vertex2_texcoord,
		output ready
	);
endinterface

// ===== rtl/core/ttb_out_if.sv =====
// ----------------------------------------------------------------------------
// ttb_out_if
// Result channel: unit tangent, unit bitangent and degenerate flag.
// ----------------------------------------------------------------------------
interface ttb_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [ttb_pkg::COMP_W-1:0] tangent_x;
	logic signed [ttb_pkg::COMP_W-1:0] tangent_y;
	logic signed [ttb_pkg::COMP_W-1:0] tangent_z;
	logic signed [ttb_pkg::COMP_W-1:0] bitangent_x;
	logic signed [ttb_pkg::COMP_W-1:0] bitangent_y;
	logic signed [ttb_pkg::COMP_W-1:0] bitangent_z;
	logic                              degenerate;

	modport source (
		output valid, tangent_x, tangent_y, tangent_z,
		output bitangent_x, bitangent_y, bitangent_z, degenerate,
		input  ready
	);
	modport sink (
		input  valid, tangent_x, tangent_y, tangent_z,
		input  bitangent_x, bitangent_y, bitangent_z, degenerate,
		output ready
	);
endinterface

// ===== rtl/core/ttb_unitize.sv =====
// ----------------------------------------------------------------------------
// ttb_unitize
// Pipelined normalizer: block scale, sum of squares, square root, divide.
// ----------------------------------------------------------------------------
module ttb_unitize #(
	parameter int  OUT_FRAC_BITS = ttb_pkg::OUT_FRAC_BITS_DEF,
	localparam int LAT           = ttb_pkg::unit_latency(OUT_FRAC_BITS)
) (
	input  logic                     clk,
	input  logic [LAT-1:0]           en,
	input  ttb_pkg::vec3_t           vec,
	output logic [OUT_FRAC_BITS:0]   quot [3]
);

	localparam int QW     = OUT_FRAC_BITS + 1;
	localparam int NUM_W  = ttb_pkg::NORM_W + QW + 1;
	localparam int DSTG   = ttb_pkg::div_stages(OUT_FRAC_BITS);
	localparam int SQ_EN  = 3;
	localparam int DIV_EN = 4 + ttb_pkg::SQ_STG;

	// stage 1: magnitudes and the largest one
	logic [ttb_pkg::MAG_W-1:0] mag_c [3];
	logic [ttb_pkg::MAG_W-1:0] max_c;
	logic [ttb_pkg::MAG_W-1:0] mag_s1 [3];
	logic [ttb_pkg::MAG_W-1:0] max_s1;

	always_comb begin
		max_c = '0;
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = ttb_pkg::MAG_W'(vec[i][ttb_pkg::VEC_W-1] ? -vec[i] : vec[i]);
			if (mag_c[i] > max_c) begin
				max_c = mag_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mag_s1 <= mag_c;
			max_s1 <= max_c;
		end
	end

	// stage 2: common shift that puts the largest magnitude at the top bit
	logic [ttb_pkg::LEAD_W-1:0]                     lead_c;
	logic [ttb_pkg::MAG_W+ttb_pkg::NORM_W-2:0]      wide_c [3];
	logic [ttb_pkg::NORM_W-1:0]                     a_s2 [3];

	always_comb begin
		lead_c = '0;
		for (int b = 0; b < ttb_pkg::MAG_W; b++) begin
			if (max_s1[b]) begin
				lead_c = ttb_pkg::LEAD_W'(b);
			end
		end
		for (int i = 0; i < 3; i++) begin
			wide_c[i] = {mag_s1[i], {(ttb_pkg::NORM_W-1){1'b0}}} >> lead_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				a_s2[i] <= wide_c[i][ttb_pkg::NORM_W-1:0];
			end
		end
	end

	// stage 3: squares
	logic [ttb_pkg::SQR_W-1:0]  sqr_s3 [3];
	logic [ttb_pkg::NORM_W-1:0] a_s3 [3];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				sqr_s3[i] <= a_s2[i] * a_s2[i];
			end
			a_s3 <= a_s2;
		end
	end

	// square root: entry 0 holds the summed radicand, then two digits a stage
	ttb_pkg::sqrt_st_t          sq_st_s [ttb_pkg::SQ_STG+1];
	logic [ttb_pkg::NORM_W-1:0] sq_a_s  [ttb_pkg::SQ_STG+1][3];

	always_ff @(posedge clk) begin
		if (en[SQ_EN]) begin
			sq_st_s[0].bits <= ttb_pkg::SUM_W'(sqr_s3[0]) + ttb_pkg::SUM_W'(sqr_s3[1])
				+ ttb_pkg::SUM_W'(sqr_s3[2]);
			sq_st_s[0].rem  <= '0;
			sq_st_s[0].root <= '0;
			sq_a_s[0]       <= a_s3;
		end
	end

	for (genvar k = 1; k <= ttb_pkg::SQ_STG; k++) begin : g_sqrt
		ttb_pkg::sqrt_st_t nx;

		always_comb begin
			nx = sq_st_s[k-1];
			for (int j = 0; j < ttb_pkg::STEPS_PER_STG; j++) begin
				if ((k - 1) * ttb_pkg::STEPS_PER_STG + j < ttb_pkg::SQ_STEPS) begin
					nx = ttb_pkg::sqrt_step(nx);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[SQ_EN+k]) begin
				sq_st_s[k] <= nx;
				sq_a_s[k]  <= sq_a_s[k-1];
			end
		end
	end

	// divide: q = floor((a * 2^(F+1) + r) / (2r)), two quotient bits a stage
	logic [ttb_pkg::REM_W-1:0] dv_rem_s [DSTG+1][3];
	logic [QW-1:0]             dv_low_s [DSTG+1][3];
	logic [QW-1:0]             dv_q_s   [DSTG+1][3];
	logic [ttb_pkg::DEN_W-1:0] dv_den_s [DSTG+1];
	logic [NUM_W-1:0]          num_c    [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = NUM_W'({sq_a_s[ttb_pkg::SQ_STG][i], {QW{1'b0}}})
				+ NUM_W'(sq_st_s[ttb_pkg::SQ_STG].root);
		end
	end

	always_ff @(posedge clk) begin
		if (en[DIV_EN]) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= ttb_pkg::REM_W'(num_c[i][NUM_W-1:QW]);
				dv_low_s[0][i] <= num_c[i][QW-1:0];
				dv_q_s[0][i]   <= '0;
			end
			dv_den_s[0] <= {sq_st_s[ttb_pkg::SQ_STG].root, 1'b0};
		end
	end

	for (genvar k = 1; k <= DSTG; k++) begin : g_div
		logic [ttb_pkg::REM_W-1:0] rem_c [3];
		logic [QW-1:0]             low_c [3];
		logic [QW-1:0]             q_c   [3];

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem_c[i] = dv_rem_s[k-1][i];
				low_c[i] = dv_low_s[k-1][i];
				q_c[i]   = dv_q_s[k-1][i];
				for (int j = 0; j < ttb_pkg::STEPS_PER_STG; j++) begin
					if ((k - 1) * ttb_pkg::STEPS_PER_STG + j < QW) begin
						rem_c[i] = {rem_c[i][ttb_pkg::REM_W-2:0], low_c[i][QW-1]};
						low_c[i] = {low_c[i][QW-2:0], 1'b0};
						if (rem_c[i] >= ttb_pkg::REM_W'(dv_den_s[k-1])) begin
							rem_c[i] = rem_c[i] - ttb_pkg::REM_W'(dv_den_s[k-1]);
							q_c[i]   = {q_c[i][QW-2:0], 1'b1};
						end else begin
							q_c[i]   = {q_c[i][QW-2:0], 1'b0};
						end
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[DIV_EN+k]) begin
				dv_rem_s[k] <= rem_c;
				dv_low_s[k] <= low_c;
				dv_q_s[k]   <= q_c;
				dv_den_s[k] <= dv_den_s[k-1];
			end
		end
	end

	assign quot = dv_q_s[DSTG];

endmodule

// ===== rtl/core/triangle_tangent_bitangent.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent
// Per-triangle unit tangent and bitangent from positions and texture coords.
// ----------------------------------------------------------------------------
// One triangle enters per cycle while triangle.ready is high, and its result
// passes the front stages, the normalizers and the output register. The depth
// is set by the square root, which resolves two root digits per stage over a
// 31-digit root, and by the divider, which resolves two quotient bits per stage.
// The pipeline collapses bubbles: each stage advances when it is empty or the
// next one advances, so a result parked at the output does not stop new beats
// from filling the stages behind it. Outputs are signed Q1.14 at the default
// OUT_FRAC_BITS of 14 (Q(15-OUT_FRAC_BITS).OUT_FRAC_BITS in general). A triangle
// with a singular UV mapping, or with an all-zero tangent or bitangent, returns
// zero vectors with degenerate set.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent #(
	parameter int OUT_FRAC_BITS = ttb_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ttb_in_if.sink      triangle,
	ttb_out_if.source   frame
);

	localparam int LU  = ttb_pkg::unit_latency(OUT_FRAC_BITS);
	localparam int N   = LU + 4;
	localparam int QW  = OUT_FRAC_BITS + 1;
	localparam int CW  = ttb_pkg::COMP_W;
	localparam int DW  = ttb_pkg::DELTA_W;
	localparam int PW  = ttb_pkg::PROD_W;
	localparam int VW  = ttb_pkg::VEC_W;

	// Stage valids and advance enables; en[N] is the downstream ready.
	logic [N-1:0] vld_q;
	logic [N:0]   en;
	logic [N-1:0] vld_next;

	always_comb begin
		en[N] = frame.ready;
		for (int k = N - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_next       = {vld_q[N-2:0], triangle.valid};
	assign triangle.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < N; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_next[k];
				end
			end
		end
	end

	// Stage 1: edge vectors and UV deltas.
	logic signed [CW-1:0] p0_c [3];
	logic signed [CW-1:0] p1_c [3];
	logic signed [CW-1:0] p2_c [3];
	logic signed [CW-1:0] uv0_c [2];
	logic signed [CW-1:0] uv1_c [2];
	logic signed [CW-1:0] uv2_c [2];
	logic signed [DW-1:0] e1_s1 [3];
	logic signed [DW-1:0] e2_s1 [3];
	logic signed [DW-1:0] d1u_s1, d1v_s1, d2u_s1, d2v_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p0_c[i] = $signed(triangle.vertex0_position[CW*i +: CW]);
			p1_c[i] = $signed(triangle.vertex1_position[CW*i +: CW]);
			p2_c[i] = $signed(triangle.vertex2_position[CW*i +: CW]);
		end
		for (int i = 0; i < 2; i++) begin
			uv0_c[i] = $signed(triangle.vertex0_texcoord[CW*i +: CW]);
			uv1_c[i] = $signed(triangle.vertex1_texcoord[CW*i +: CW]);
			uv2_c[i] = $signed(triangle.vertex2_texcoord[CW*i +: CW]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= DW'(p1_c[i]) - DW'(p0_c[i]);
				e2_s1[i] <= DW'(p2_c[i]) - DW'(p0_c[i]);
			end
			d1u_s1 <= DW'(uv1_c[0]) - DW'(uv0_c[0]);
			d1v_s1 <= DW'(uv1_c[1]) - DW'(uv0_c[1]);
			d2u_s1 <= DW'(uv2_c[0]) - DW'(uv0_c[0]);
			d2v_s1 <= DW'(uv2_c[1]) - DW'(uv0_c[1]);
		end
	end

	// Stage 2: all cross products in parallel.
	logic signed [PW-1:0] ta_s2 [3];
	logic signed [PW-1:0] tb_s2 [3];
	logic signed [PW-1:0] ba_s2 [3];
	logic signed [PW-1:0] bb_s2 [3];
	logic signed [PW-1:0] deta_s2, detb_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				ta_s2[i] <= d2v_s1 * e1_s1[i];
				tb_s2[i] <= d1v_s1 * e2_s1[i];
				ba_s2[i] <= d1u_s1 * e2_s1[i];
				bb_s2[i] <= d2u_s1 * e1_s1[i];
			end
			deta_s2 <= d1u_s1 * d2v_s1;
			detb_s2 <= d2u_s1 * d1v_s1;
		end
	end

	// Stage 3: combine, fold in the sign of 1/det, flag degenerate frames.
	logic signed [VW-1:0] det_c;
	logic signed [VW-1:0] tr_c [3];
	logic signed [VW-1:0] br_c [3];
	ttb_pkg::vec3_t       t_c, b_c;
	ttb_pkg::meta_t       meta_c;
	ttb_pkg::vec3_t       t_s3, b_s3;
	ttb_pkg::meta_t       meta_s [LU+1];

	always_comb begin
		det_c = VW'(deta_s2) - VW'(detb_s2);
		for (int i = 0; i < 3; i++) begin
			tr_c[i]          = VW'(ta_s2[i]) - VW'(tb_s2[i]);
			br_c[i]          = VW'(ba_s2[i]) - VW'(bb_s2[i]);
			t_c[i]           = det_c[VW-1] ? -tr_c[i] : tr_c[i];
			b_c[i]           = det_c[VW-1] ? -br_c[i] : br_c[i];
			meta_c.tneg[i]   = t_c[i][VW-1];
			meta_c.bneg[i]   = b_c[i][VW-1];
		end
		meta_c.degen = (det_c == '0)
			|| (t_c[0] == '0 && t_c[1] == '0 && t_c[2] == '0)
			|| (b_c[0] == '0 && b_c[1] == '0 && b_c[2] == '0);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t_s3      <= t_c;
			b_s3      <= b_c;
			meta_s[0] <= meta_c;
		end
	end

	// Carry signs and the degenerate flag alongside the normalizers.
	for (genvar k = 1; k <= LU; k++) begin : g_meta
		always_ff @(posedge clk) begin
			if (en[2+k]) begin
				meta_s[k] <= meta_s[k-1];
			end
		end
	end

	logic [QW-1:0] tq [3];
	logic [QW-1:0] bq [3];

	ttb_unitize #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_tan (
		.clk  (clk),
		.en   (en[2+LU:3]),
		.vec  (t_s3),
		.quot (tq)
	);

	ttb_unitize #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_bit (
		.clk  (clk),
		.en   (en[2+LU:3]),
		.vec  (b_s3),
		.quot (bq)
	);

	// Saturate the unsigned quotient and apply the component sign.
	function automatic logic signed [CW-1:0] to_fixed(logic [QW-1:0] q, logic neg);
		logic [CW:0]   ext;
		logic [CW-1:0] sat;
		ext = (CW+1)'(q);
		sat = (ext > (CW+1)'(ttb_pkg::Q_SAT)) ? CW'(ttb_pkg::Q_SAT) : ext[CW-1:0];
		return $signed(neg ? CW'(0) - sat : sat);
	endfunction

	// Output register: zero both vectors on a degenerate frame.
	logic signed [CW-1:0] tan_q [3];
	logic signed [CW-1:0] bit_q [3];
	logic                 degen_q;

	always_ff @(posedge clk) begin
		if (en[N-1]) begin
			for (int i = 0; i < 3; i++) begin
				tan_q[i] <= meta_s[LU].degen ? '0 : to_fixed(tq[i], meta_s[LU].tneg[i]);
				bit_q[i] <= meta_s[LU].degen ? '0 : to_fixed(bq[i], meta_s[LU].bneg[i]);
			end
			degen_q <= meta_s[LU].degen;
		end
	end

	assign frame.valid       = vld_q[N-1];
	assign frame.tangent_x   = tan_q[0];
	assign frame.tangent_y   = tan_q[1];
	assign frame.tangent_z   = tan_q[2];
	assign frame.bitangent_x = bit_q[0];
	assign frame.bitangent_y = bit_q[1];
	assign frame.bitangent_z = bit_q[2];
	assign frame.degenerate  = degen_q;

endmodule
